// ===== rtl/core/sst_pkg.sv =====
package sst_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_MAX_SCOPE   = 15;
    localparam int DEF_KEY_BITS    = 32;

    typedef enum logic [2:0] {
        KIND_DECL   = 3'd0,
        KIND_ASSIGN = 3'd1,
        KIND_ARITH  = 3'd2,
        KIND_ENTER  = 3'd3,
        KIND_EXIT   = 3'd4
    } kind_e;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_DUP      = 3'd1,
        STAT_LEFT     = 3'd2,
        STAT_RIGHT    = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_SCOPE    = 3'd5
    } status_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_e;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] left_key;
        logic        left_is_name;
        logic [31:0] right_key;
        logic        right_is_name;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] scope_depth;
    } rsp_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic live;
        logic lhit;
        logic rhit;
        logic dup;
        logic free_seen;
    } tok_t;

    // commit command broadcast to every cell
    typedef struct packed {
        logic decl;
        logic leave;
    } cmd_t;

endpackage

// ===== rtl/core/sst_cell.sv =====
module sst_cell
    import sst_pkg::*;
#(
    parameter int KW = 32,
    parameter int SW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [KW-1:0] lkey,
    input  logic [KW-1:0] rkey,
    input  logic [SW-1:0] level,
    input  cmd_t          cmd,
    input  tok_t          tok_in,
    output tok_t          tok_out
);

    logic          valid_reg, valid_next;
    logic          cand_reg, cand_next;
    logic [KW-1:0] key_reg;
    logic [SW-1:0] scope_reg;
    tok_t          tok_reg, tok_next;
    logic          match_l, match_r, match_dup;
    logic          wr_en;

    assign match_l   = valid_reg && (key_reg == lkey);
    assign match_r   = valid_reg && (key_reg == rkey);
    assign match_dup = match_l && (scope_reg == level);
    assign wr_en     = cmd.decl && cand_reg;

    always_comb
    begin
        tok_next           = tok_in;
        tok_next.lhit      = tok_in.lhit | match_l;
        tok_next.rhit      = tok_in.rhit | match_r;
        tok_next.dup       = tok_in.dup | match_dup;
        tok_next.free_seen = tok_in.free_seen | !valid_reg;

        // first free cell on the token's path claims the pending insert
        cand_next = cand_reg;
        if (tok_in.live)
        begin
            cand_next = !valid_reg && !tok_in.free_seen;
        end

        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next = 1'b1;
        end
        else if (cmd.leave && valid_reg && (scope_reg == level))
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg   <= lkey;
            scope_reg <= level;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/sst_ctrl.sv =====
module sst_ctrl
    import sst_pkg::*;
#(
    parameter int MAX_SCOPE = DEF_MAX_SCOPE,
    parameter int KW        = 32,
    parameter int SW        = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  req_t          req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rsp_t          rsp,
    output logic [KW-1:0] lkey,
    output logic [KW-1:0] rkey,
    output logic [SW-1:0] level,
    output cmd_t          cmd,
    output tok_t          tok_first,
    input  tok_t          tok_last
);

    state_e        state_reg, state_next;
    logic [2:0]    kind_reg, kind_next;
    logic          lname_reg, lname_next;
    logic          rname_reg, rname_next;
    logic [KW-1:0] lkey_reg, lkey_next;
    logic [KW-1:0] rkey_reg, rkey_next;
    logic [SW-1:0] level_reg, level_next;
    logic          start_reg, start_next;
    tok_t          flag_reg, flag_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    always_comb
    begin
        logic [2:0]    status;
        logic [SW+3:0] depth_ext;

        state_next     = state_reg;
        kind_next      = kind_reg;
        lname_next     = lname_reg;
        rname_next     = rname_reg;
        lkey_next      = lkey_reg;
        rkey_next      = rkey_reg;
        level_next     = level_reg;
        start_next     = 1'b0;
        flag_next      = flag_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        req_stall      = 1'b1;
        status         = STAT_OK;
        depth_ext      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    kind_next  = req.kind;
                    lname_next = req.left_is_name;
                    rname_next = req.right_is_name;
                    lkey_next  = req.left_key[KW-1:0];
                    rkey_next  = req.right_key[KW-1:0];
                    start_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_last.live)
                begin
                    flag_next  = tok_last;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    unique case (kind_reg)
                        KIND_DECL:
                        begin
                            if (flag_reg.dup)
                                status = STAT_DUP;
                            else if (!flag_reg.free_seen)
                                status = STAT_FULL;
                            else
                                cmd.decl = 1'b1;
                        end
                        KIND_ASSIGN:
                        begin
                            if (!flag_reg.lhit)
                                status = STAT_LEFT;
                            else if (rname_reg && !flag_reg.rhit)
                                status = STAT_RIGHT;
                        end
                        KIND_ARITH:
                        begin
                            if (lname_reg && !flag_reg.lhit)
                                status = STAT_LEFT;
                            else if (rname_reg && !flag_reg.rhit)
                                status = STAT_RIGHT;
                        end
                        KIND_ENTER:
                        begin
                            if (level_reg >= SW'(MAX_SCOPE))
                                status = STAT_SCOPE;
                            else
                                level_next = level_reg + 1'b1;
                        end
                        KIND_EXIT:
                        begin
                            if (level_reg == '0)
                                status = STAT_SCOPE;
                            else
                            begin
                                cmd.leave  = 1'b1;
                                level_next = level_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            status = STAT_OK;
                        end
                    endcase
                    depth_ext            = {4'b0, level_next};
                    rsp_next.status      = status;
                    rsp_next.scope_depth = depth_ext[3:0];
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            start_reg     <= start_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        lname_reg <= lname_next;
        rname_reg <= rname_next;
        lkey_reg  <= lkey_next;
        rkey_reg  <= rkey_next;
        flag_reg  <= flag_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        tok_first      = '0;
        tok_first.live = start_reg;
    end

    assign lkey      = lkey_reg;
    assign rkey      = rkey_reg;
    assign level     = level_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/scoped_symbol_table_checker.sv =====
// Channel  Signals                     Payload
// request  req_valid / req_stall       req (req_t)
// result   rsp_valid / rsp_stall       rsp (rsp_t)
//
// One request at a time; after its transfer the search token steps through the cell chain one cell
// a clock, the block registers the token's flags at the end of the chain and then its result,
// and the next request can transfer once that result is registered.
// The result register lets a new request transfer in while a result waits.
// Reset clears the scope level and all cell valid bits; no clearing pass.
// A stalled result holds the block in its final state before commit.
module scoped_symbol_table_checker
    import sst_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_SCOPE   = DEF_MAX_SCOPE,
    parameter int KEY_BITS    = DEF_KEY_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int SW = $clog2(MAX_SCOPE + 1);

    logic [KW-1:0] lkey;
    logic [KW-1:0] rkey;
    logic [SW-1:0] level;
    cmd_t          cmd;
    tok_t          tok [TABLE_DEPTH+1];

    sst_ctrl #(
        .MAX_SCOPE (MAX_SCOPE),
        .KW        (KW),
        .SW        (SW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .lkey      (lkey),
        .rkey      (rkey),
        .level     (level),
        .cmd       (cmd),
        .tok_first (tok[0]),
        .tok_last  (tok[TABLE_DEPTH])
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        sst_cell #(
            .KW (KW),
            .SW (SW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .lkey    (lkey),
            .rkey    (rkey),
            .level   (level),
            .cmd     (cmd),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

endmodule

// ===== rtl/core/sst_checker.sv =====
module sst_checker
    import sst_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // a held result keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status <= STAT_SCOPE))
        else $error("status code out of range");

    // one request at a time: busy right after a transfer in
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while busy");

    // a new result only appears while a request is being worked on
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a request in flight");

endmodule

bind scoped_symbol_table_checker sst_checker u_sst_checker (.*);
